// ===== hw/rtl/ray_box_closest_hit_core_defines.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; each macro expects signals clock and reset in scope.
`ifndef RAY_BOX_CLOSEST_HIT_CORE_DEFINES_SVH
`define RAY_BOX_CLOSEST_HIT_CORE_DEFINES_SVH

// same-cycle implication
`define RBCH_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define RBCH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== hw/rtl/rbch_pkg.sv =====
// Shared constants, state encoding and control structs for the ray/box hit core.
// No dependencies.
package rbch_pkg;

   localparam int COORD_WIDTH_DEF   = 24;
   localparam int DIR_FRAC_BITS_DEF = 14;
   localparam int MAXD_RESET        = 128000;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_APPLY  = 5'b01000,
      ST_FINISH = 5'b10000
   } rbch_state_type;

   // slab edge being processed: x low, x high, y low, y high
   localparam logic [1:0] OP_X_LO = 2'd0;
   localparam logic [1:0] OP_X_HI = 2'd1;
   localparam logic [1:0] OP_Y_LO = 2'd2;
   localparam logic [1:0] OP_Y_HI = 2'd3;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       div_step;
      logic       apply;
      logic       finish;
      logic [1:0] op;
   } rbch_cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } rbch_status_type;

endpackage

// ===== hw/rtl/rbch_ctrl.sv =====
// Sequencer for the ray/box hit core: steps four slab divisions per word.
// Depends on rbch_pkg.
module rbch_ctrl import rbch_pkg::*; #(
   parameter int QUO_WIDTH = 39
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  rbch_status_type status,
   output rbch_cmd_type    cmd
);

   localparam int CNT_W = $clog2(QUO_WIDTH);

   rbch_state_type state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = OP_X_LO;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_WIDTH - 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (op_ff == OP_Y_HI) begin
               state_in = ST_FINISH;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_FINISH: begin
            // hold while the result word would overwrite an untaken one
            if (!status.last || status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_X_LO;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/rbch_datapath.sv =====
// Datapath of the ray/box hit core: item registers, shared restoring divider,
// slab interval, nearest-hit tracking and result register. Depends on rbch_pkg.
module rbch_datapath import rbch_pkg::*; #(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
   localparam int DIST_W = COORD_WIDTH - 1,
   localparam int DIR_W  = DIR_FRAC_BITS + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rbch_cmd_type                  cmd,
   output rbch_status_type               status,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [DIR_W-1:0]       req_dir_x,
   input  logic signed [DIR_W-1:0]       req_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_left,
   input  logic signed [COORD_WIDTH-1:0] req_box_top,
   input  logic [DIST_W-1:0]             req_box_width,
   input  logic [DIST_W-1:0]             req_box_height,
   input  logic                          req_last_box,
   input  logic                          csr_valid,
   input  logic [DIST_W-1:0]             csr_max_distance,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [DIST_W-1:0]             rsp_hit_distance,
   output logic                          rsp_any_hit
);

   localparam int EDGE_W = COORD_WIDTH + 1;
   localparam int DLT_W  = COORD_WIDTH + 2;
   localparam int MAG_W  = COORD_WIDTH + 1;
   localparam int Q_W    = MAG_W + DIR_FRAC_BITS;
   localparam int T_W    = Q_W + 2;
   localparam logic signed [T_W-1:0] T_NEG_INF = {1'b1, {(T_W-1){1'b0}}};
   localparam logic signed [T_W-1:0] T_POS_INF = {1'b0, {(T_W-1){1'b1}}};

   // item registers
   logic signed [COORD_WIDTH-1:0] ox_ff, oy_ff, bl_ff, bt_ff;
   logic signed [DIR_W-1:0]       dx_ff, dy_ff;
   logic [DIST_W-1:0]             bw_ff, bh_ff;
   logic                          last_ff;

   // divider and slab state
   logic [Q_W-1:0]          quo_ff;
   logic [DIR_W-1:0]        rem_ff, den_ff;
   logic                    neg_ff;
   logic signed [T_W-1:0]   t1_ff, tmin_ff, tmax_ff;
   logic                    ok_ff;

   // run state and config
   logic [DIST_W-1:0] maxd_ff, nearest_ff;
   logic              hit_seen_ff;
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_hit_ff;

   logic signed [COORD_WIDTH-1:0] sel_org, sel_lo;
   logic [DIST_W-1:0]             sel_ext;
   logic signed [DIR_W-1:0]       sel_dir;
   logic signed [EDGE_W-1:0]      sel_lo_w, sel_hi_w, sel_edge;
   logic signed [DLT_W-1:0]       delta, delta_abs;
   logic [DIR_W-1:0]              dir_abs;
   logic [DIR_W:0]                rem_sh;
   logic                          ge;
   logic signed [T_W-1:0]         tq, tlo, thi;
   logic                          in_slab, dir_zero;
   logic signed [T_W-1:0]         dval;
   logic                          take;
   logic [DIST_W-1:0]             nearest_nx;
   logic                          hit_nx;

   always_comb begin
      sel_org  = cmd.op[1] ? oy_ff : ox_ff;
      sel_lo   = cmd.op[1] ? bt_ff : bl_ff;
      sel_ext  = cmd.op[1] ? bh_ff : bw_ff;
      sel_dir  = cmd.op[1] ? dy_ff : dx_ff;
      sel_lo_w = EDGE_W'(sel_lo);
      sel_hi_w = sel_lo_w + $signed({2'b00, sel_ext});
      sel_edge = cmd.op[0] ? sel_hi_w : sel_lo_w;
      delta    = DLT_W'(sel_edge) - DLT_W'(sel_org);
      delta_abs = delta[DLT_W-1] ? -delta : delta;
      dir_abs   = sel_dir[DIR_W-1] ? DIR_W'(-sel_dir) : DIR_W'(sel_dir);
      dir_zero  = (sel_dir == '0);
      in_slab   = !((DLT_W'(sel_org) < DLT_W'(sel_lo_w)) ||
                    (DLT_W'(sel_org) > DLT_W'(sel_hi_w)));
   end

   // one quotient bit per step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[Q_W-1]};
      ge     = (rem_sh >= {1'b0, den_ff});
   end

   // floored signed quotient
   always_comb begin
      if (neg_ff) begin
         tq = -$signed({2'b00, quo_ff}) - T_W'(rem_ff != '0);
      end else begin
         tq = $signed({2'b00, quo_ff});
      end
      tlo = (t1_ff < tq) ? t1_ff : tq;
      thi = (t1_ff < tq) ? tq : t1_ff;
   end

   always_comb begin
      dval = (tmin_ff >= 0) ? tmin_ff : tmax_ff;
      take = ok_ff && (tmax_ff >= 0) && (tmin_ff <= tmax_ff) && (dval >= 0) &&
             (dval < $signed({{(T_W-DIST_W){1'b0}}, nearest_ff}));
      nearest_nx = take ? dval[DIST_W-1:0] : nearest_ff;
      hit_nx     = take || hit_seen_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ox_ff   <= req_origin_x;
         oy_ff   <= req_origin_y;
         dx_ff   <= req_dir_x;
         dy_ff   <= req_dir_y;
         bl_ff   <= req_box_left;
         bt_ff   <= req_box_top;
         bw_ff   <= req_box_width;
         bh_ff   <= req_box_height;
      end
      if (cmd.div_start) begin
         quo_ff <= {delta_abs[MAG_W-1:0], {DIR_FRAC_BITS{1'b0}}};
         rem_ff <= '0;
         den_ff <= dir_abs;
         neg_ff <= delta[DLT_W-1] ^ sel_dir[DIR_W-1];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? DIR_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIR_W-1:0];
         quo_ff <= {quo_ff[Q_W-2:0], ge};
      end
      if (cmd.load) begin
         tmin_ff <= T_NEG_INF;
         tmax_ff <= T_POS_INF;
      end else if (cmd.apply) begin
         if (!cmd.op[0]) begin
            t1_ff <= tq;
         end else if (!dir_zero) begin
            if (tlo > tmin_ff) tmin_ff <= tlo;
            if (thi < tmax_ff) tmax_ff <= thi;
         end
      end
      if (cmd.finish && last_ff) begin
         rsp_dist_ff <= hit_nx ? nearest_nx : maxd_ff;
         rsp_hit_ff  <= hit_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= 1'b0;
         ok_ff        <= 1'b0;
         maxd_ff      <= DIST_W'(MAXD_RESET);
         nearest_ff   <= DIST_W'(MAXD_RESET);
         hit_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            last_ff <= req_last_box;
            ok_ff   <= 1'b1;
         end else if (cmd.apply && cmd.op[0] && dir_zero && !in_slab) begin
            ok_ff <= 1'b0;
         end
         if (csr_valid) begin
            maxd_ff     <= csr_max_distance;
            nearest_ff  <= csr_max_distance;
            hit_seen_ff <= 1'b0;
         end else if (cmd.finish) begin
            if (last_ff) begin
               nearest_ff  <= maxd_ff;
               hit_seen_ff <= 1'b0;
            end else begin
               nearest_ff  <= nearest_nx;
               hit_seen_ff <= hit_nx;
            end
         end
         if (cmd.finish && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_distance = rsp_dist_ff;
   assign rsp_any_hit      = rsp_hit_ff;

endmodule

// ===== hw/rtl/ray_box_closest_hit_core.sv =====
// Nearest ray/rectangle hit over a run of rectangles, 2D slab test.
// Each word takes four quotients through one radix-2 divider, one after another;
// a result is registered when the last word of a run finishes.
// One word in flight; the result register frees the engine once loaded.
// Synchronous active-high reset: max distance 128000, no hit, no result.
module ray_box_closest_hit_core import rbch_pkg::*; #(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_WIDTH-1:0]     req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]     req_origin_y,
   input  logic signed [DIR_FRAC_BITS+1:0]   req_dir_x,
   input  logic signed [DIR_FRAC_BITS+1:0]   req_dir_y,
   input  logic signed [COORD_WIDTH-1:0]     req_box_left,
   input  logic signed [COORD_WIDTH-1:0]     req_box_top,
   input  logic [COORD_WIDTH-2:0]            req_box_width,
   input  logic [COORD_WIDTH-2:0]            req_box_height,
   input  logic                              req_last_box,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [COORD_WIDTH-2:0]            csr_max_distance,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [COORD_WIDTH-2:0]            rsp_hit_distance,
   output logic                              rsp_any_hit
);

   localparam int QUO_WIDTH = COORD_WIDTH + 1 + DIR_FRAC_BITS;

   rbch_cmd_type    cmd;
   rbch_status_type status;

   assign csr_ready = 1'b1;

   rbch_ctrl #(.QUO_WIDTH(QUO_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rbch_datapath #(
      .COORD_WIDTH   (COORD_WIDTH),
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_dir_x        (req_dir_x),
      .req_dir_y        (req_dir_y),
      .req_box_left     (req_box_left),
      .req_box_top      (req_box_top),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_last_box     (req_last_box),
      .csr_valid        (csr_valid && csr_ready),
      .csr_max_distance (csr_max_distance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit_distance (rsp_hit_distance),
      .rsp_any_hit      (rsp_any_hit)
   );

endmodule

// ===== hw/rtl/rbch_checker.sv =====
// Port-level checks for the ray/box hit core, bound to the top level.
// Depends on rbch_pkg and ray_box_closest_hit_core_defines.svh.
`include "ray_box_closest_hit_core_defines.svh"
module rbch_checker import rbch_pkg::*; #(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   req_last_box,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [COORD_WIDTH-2:0] rsp_hit_distance,
   input logic                   rsp_any_hit
);

   `RBCH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `RBCH_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_hit_distance) && $stable(rsp_any_hit))
   `RBCH_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `RBCH_ASSERT_NEXT(a_no_rsp_mid_run, req_valid && !req_stall && !req_last_box && !rsp_valid, !rsp_valid)

endmodule

bind ray_box_closest_hit_core rbch_checker #(
   .COORD_WIDTH   (COORD_WIDTH),
   .DIR_FRAC_BITS (DIR_FRAC_BITS)
) u_rbch_checker (.*);
